@@ rtl/lbs_pkg.sv @@
// shared constants and types for the skinning kernel
package lbs_pkg;
	localparam int MAX_JOINTS = 64;
	localparam int FRAC_BITS = 16;
	localparam int WEIGHT_BITS = 16;
	localparam logic [16:0] WEIGHT_ONE = 17'd65536;
	localparam logic [1:0] CMD_XFORM = 2'd0;
	localparam logic [1:0] CMD_REST = 2'd1;
	localparam logic [1:0] CMD_VERT = 2'd2;

	typedef struct packed {
		logic [1:0] cmd;
		logic [5:0] joint_index;
		logic [3:0] element;
		logic signed [31:0] load_value;
		logic signed [31:0] vert_x;
		logic signed [31:0] vert_y;
		logic signed [31:0] vert_z;
		logic [16:0] weight;
		logic last_joint;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic saturated;
	} out_item_t;
endpackage

@@ rtl/lbs_if.sv @@
// valid/ready channel interfaces
interface lbs_in_if;
	logic valid;
	logic ready;
	lbs_pkg::in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface lbs_out_if;
	logic valid;
	logic ready;
	lbs_pkg::out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ rtl/lbs_ram.sv @@
// generic simple dual port ram (one write port, one read port) with registered read
module lbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/linear_blend_skinning.sv @@
// linear blend skinning kernel top level
// load items: one transfer per cycle while idle, written into the tables at the accepting edge
// unless joint or element is out of range; vertex item: run steps (rest reads, one shared
// 32x33 multiply, row weighting and accumulate), then the output state; a joint out of range
// skips the run; only last_joint sends a result; next item taken in idle; a held result stalls
// arst_n clears control state and the accumulators; tables are undefined until written
module linear_blend_skinning #(
	parameter int MAX_JOINTS = lbs_pkg::MAX_JOINTS,
	parameter int FRAC_BITS = lbs_pkg::FRAC_BITS
) (
	input logic clk,
	input logic arst_n,
	lbs_in_if.sink in_ch,
	lbs_out_if.source out_ch
);
	localparam int TD = MAX_JOINTS * 12;
	localparam int RD = MAX_JOINTS * 3;
	localparam int TA = $clog2(TD);
	localparam int RA = $clog2(RD);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_OUT  = 3'b100
	} state_t;
	state_t state_q;

	lbs_pkg::in_item_t it_q;
	logic [5:0] step_q;
	logic [31:0] t_rd, r_rd;
	logic [TA-1:0] t_ra;
	logic [RA-1:0] r_ra;
	logic [3:0] rd_elem, e_c;
	logic [1:0] col_c, axis_c, d_idx;
	logic signed [31:0] vsel;
	logic signed [32:0] d_q [3];
	logic signed [63:0] s_q;
	logic signed [63:0] acc_q [3];
	logic signed [64:0] prod_q;
	logic signed [63:0] prod_sh;
	logic [16:0] w_c;
	logic in_rng, t_we, r_we, acc_in, out_load;
	logic signed [46:0] s_cl;
	logic signed [64:0] wprod, wprod_q;
	logic signed [63:0] contrib, sclamp, sum_c;
	logic signed [64:0] sum_w;
	logic [1:0] arow_q;
	logic wvalid_q;

	assign in_rng = 32'(in_ch.data.joint_index) < MAX_JOINTS;
	assign in_ch.ready = (state_q == ST_IDLE);
	assign acc_in = in_ch.valid && in_ch.ready;
	assign t_we = acc_in && in_ch.data.cmd == lbs_pkg::CMD_XFORM && in_rng
		&& in_ch.data.element < 4'd12;
	assign r_we = acc_in && in_ch.data.cmd == lbs_pkg::CMD_REST && in_rng
		&& in_ch.data.element < 4'd3;

	// step schedule: steps 0..2 read rest coords, d[k] formed in steps 1..3
	// steps 3..14 read transform elements 0..11, data used in steps 4..15
	// row r sum ready in step 8+4r, weighted product registered, accumulated in step 9+4r
	assign rd_elem = (step_q >= 6'd3 && step_q <= 6'd14) ? 4'(step_q - 6'd3) : 4'd0;
	assign axis_c = (step_q <= 6'd2) ? step_q[1:0] : 2'd0;
	assign t_ra = TA'(32'(it_q.joint_index) * 12 + 32'(rd_elem));
	assign r_ra = RA'(32'(it_q.joint_index) * 3 + 32'(axis_c));
	assign e_c = 4'(step_q - 6'd4);
	assign col_c = e_c[1:0];
	assign d_idx = 2'(step_q - 6'd1);
	assign vsel = (d_idx == 2'd0) ? it_q.vert_x : (d_idx == 2'd1) ? it_q.vert_y : it_q.vert_z;

	lbs_ram #(.WIDTH(32), .DEPTH(TD)) u_xf (.clk, .we(t_we),
		.waddr(TA'(32'(in_ch.data.joint_index) * 12 + 32'(in_ch.data.element))),
		.wdata(in_ch.data.load_value), .raddr(t_ra), .rdata(t_rd));
	lbs_ram #(.WIDTH(32), .DEPTH(RD)) u_rest (.clk, .we(r_we),
		.waddr(RA'(32'(in_ch.data.joint_index) * 3 + 32'(in_ch.data.element))),
		.wdata(in_ch.data.load_value), .raddr(r_ra), .rdata(r_rd));

	assign w_c = (it_q.weight > lbs_pkg::WEIGHT_ONE) ? lbs_pkg::WEIGHT_ONE : it_q.weight;
	// floor shift of the product
	assign prod_sh = 64'(prod_q >>> FRAC_BITS);

	// silent row clamp, then weight in unsigned q1.16
	assign sclamp = (s_q > 64'sd70368744177663) ? 64'sd70368744177663 :
		(s_q < -64'sd70368744177664) ? -64'sd70368744177664 : s_q;
	assign s_cl = 47'(sclamp);
	assign wprod = s_cl * $signed({1'b0, w_c});

	// datapath registers
	always_ff @(posedge clk) begin
		if (acc_in && in_ch.data.cmd == lbs_pkg::CMD_VERT) it_q <= in_ch.data;
		if (state_q == ST_RUN) begin
			if (step_q >= 6'd1 && step_q <= 6'd3)
				d_q[d_idx] <= 33'(vsel) - 33'($signed(r_rd));
			if (step_q >= 6'd4 && step_q <= 6'd15) begin
				// element k times d[k], registered, summed in the next step; column 3 is added as is
				if (col_c != 2'd3) prod_q <= $signed(t_rd) * d_q[col_c];
				if (col_c == 2'd1) s_q <= prod_sh;
				else if (col_c == 2'd2) s_q <= s_q + prod_sh;
				else if (col_c == 2'd3) s_q <= s_q + prod_sh + 64'($signed(t_rd));
			end
			if (step_q inside {6'd8, 6'd12, 6'd16})
				arow_q <= (step_q == 6'd8) ? 2'd0 : (step_q == 6'd12) ? 2'd1 : 2'd2;
		end
		wprod_q <= wprod;
	end

	// weighted row, floor shift, saturating add
	assign contrib = 64'(wprod_q >>> lbs_pkg::WEIGHT_BITS);
	assign sum_w = 65'(acc_q[arow_q]) + 65'(contrib);
	assign sum_c = (sum_w > 65'sh0_7FFF_FFFF_FFFF_FFFF) ? 64'sh7FFF_FFFF_FFFF_FFFF :
		(sum_w < -65'sh0_8000_0000_0000_0000) ? 64'sh8000_0000_0000_0000 : 64'(sum_w);

	// a last_joint result goes out when the output register is free or being emptied
	assign out_load = state_q == ST_OUT && it_q.last_joint && (!out_ch.valid || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			wvalid_q <= 1'b0;
			for (int i = 0; i < 3; i++) acc_q[i] <= '0;
			out_ch.valid <= 1'b0;
		end else begin
			wvalid_q <= (state_q == ST_RUN) && (step_q inside {6'd8, 6'd12, 6'd16});
			case (state_q)
				ST_IDLE: begin
					if (acc_in && in_ch.data.cmd == lbs_pkg::CMD_VERT) begin
						step_q <= '0;
						state_q <= in_rng ? ST_RUN : ST_OUT;
					end
				end
				ST_RUN: begin
					step_q <= step_q + 6'd1;
					if (step_q == 6'd17) state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!it_q.last_joint || out_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (out_load) out_ch.valid <= 1'b1;
			else if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				if (out_load) acc_q[i] <= '0;
				else if (wvalid_q && arow_q == 2'(i)) acc_q[i] <= sum_c;
			end
		end
	end

	function automatic logic [32:0] clip(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return {1'b1, 32'h7FFF_FFFF};
		if (v < -64'sd2147483648) return {1'b1, 32'h8000_0000};
		return {1'b0, v[31:0]};
	endfunction
	logic [32:0] cx, cy, cz;
	assign cx = clip(acc_q[0]);
	assign cy = clip(acc_q[1]);
	assign cz = clip(acc_q[2]);
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_ch.data.out_x <= cx[31:0];
			out_ch.data.out_y <= cy[31:0];
			out_ch.data.out_z <= cz[31:0];
			out_ch.data.saturated <= cx[32] | cy[32] | cz[32];
		end
	end

`ifndef ASSERT_OFF
	a_noacc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !in_ch.ready) else $error("accept while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("result dropped");
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> step_q <= 6'd17) else $error("step overrun");
`endif
endmodule
